### sv/voxel_volume_smoothing_assert.svh
// Assertion macros shared by the voxel volume smoothing checker.
`ifndef VOXEL_VOLUME_SMOOTHING_ASSERT_SVH
`define VOXEL_VOLUME_SMOOTHING_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define VVS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must never be seen outside reset.
`define VVS_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### sv/vvs_pkg.sv
// Shared types and constants of the voxel volume smoothing block.
package vvs_pkg;

    localparam int MAX_X_DEF = 64;
    localparam int MAX_Y_DEF = 64;
    localparam int MAX_Z_DEF = 64;

    localparam int IDX_W  = 6;
    localparam int VOX_W  = 8;
    localparam int SIZE_W = 7;
    localparam int PASS_W = 8;
    localparam int CFG_W  = 8;
    localparam int ACC_W  = 12;
    localparam int TAP_W  = 3;

    // Reciprocal of three in 17 fractional bits; exact for 16-bit operands.
    localparam logic [15:0] RECIP3 = 16'hAAAB;
    localparam int RECIP_SHIFT = 17;

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_READ  = 2'd1,
        MODE_RUN   = 2'd2,
        MODE_NONE  = 2'd3
    } vvs_mode_t;

    typedef enum logic [1:0] {
        REG_SIZE_X = 2'd0,
        REG_SIZE_Y = 2'd1,
        REG_SIZE_Z = 2'd2,
        REG_PASSES = 2'd3
    } vvs_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_PASS,
        ST_GATHER,
        ST_DIVIDE,
        ST_STORE,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_REPLY
    } vvs_state_t;

    typedef struct packed {
        logic [1:0]       mode;
        logic [IDX_W-1:0] x_index;
        logic [IDX_W-1:0] y_index;
        logic [IDX_W-1:0] z_index;
        logic [VOX_W-1:0] voxel_value;
    } vvs_cmd_t;

    typedef struct packed {
        logic [VOX_W-1:0] read_value;
        logic             status;
    } vvs_result_t;

    typedef struct packed {
        logic accept;
        logic access;
        logic pass_init;
        logic gather;
        logic divide;
        logic store;
        logic copy_rd;
        logic copy_wr;
    } vvs_ctl_t;

    typedef struct packed {
        logic run_end;
        logic gather_end;
        logic plane_end;
        logic x_end;
    } vvs_stat_t;

endpackage

### sv/vvs_ctrl.sv
// Controller state machine of the voxel volume smoothing block.
module vvs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        mode,
    input  vvs_pkg::vvs_stat_t stat,
    output vvs_pkg::vvs_ctl_t ctl,
    output logic              busy,
    output logic              done
);

    vvs_pkg::vvs_state_t state_reg;
    vvs_pkg::vvs_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vvs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        busy       = 1'b1;
        done       = 1'b0;
        unique case (state_reg)
            vvs_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    ctl.accept = 1'b1;
                    if (mode == vvs_pkg::MODE_RUN)
                    begin
                        state_next = vvs_pkg::ST_PASS;
                    end
                    else
                    begin
                        state_next = vvs_pkg::ST_ACCESS;
                    end
                end
            end
            vvs_pkg::ST_ACCESS:
            begin
                ctl.access = 1'b1;
                state_next = vvs_pkg::ST_REPLY;
            end
            vvs_pkg::ST_PASS:
            begin
                if (stat.run_end)
                begin
                    state_next = vvs_pkg::ST_REPLY;
                end
                else
                begin
                    ctl.pass_init = 1'b1;
                    state_next    = vvs_pkg::ST_GATHER;
                end
            end
            vvs_pkg::ST_GATHER:
            begin
                ctl.gather = 1'b1;
                if (stat.gather_end)
                begin
                    state_next = vvs_pkg::ST_DIVIDE;
                end
            end
            vvs_pkg::ST_DIVIDE:
            begin
                ctl.divide = 1'b1;
                state_next = vvs_pkg::ST_STORE;
            end
            vvs_pkg::ST_STORE:
            begin
                ctl.store = 1'b1;
                if (stat.plane_end)
                begin
                    state_next = vvs_pkg::ST_COPY_RD;
                end
                else
                begin
                    state_next = vvs_pkg::ST_GATHER;
                end
            end
            vvs_pkg::ST_COPY_RD:
            begin
                ctl.copy_rd = 1'b1;
                state_next  = vvs_pkg::ST_COPY_WR;
            end
            vvs_pkg::ST_COPY_WR:
            begin
                ctl.copy_wr = 1'b1;
                priority if (stat.plane_end && stat.x_end)
                begin
                    state_next = vvs_pkg::ST_PASS;
                end
                else if (stat.plane_end)
                begin
                    state_next = vvs_pkg::ST_GATHER;
                end
                else
                begin
                    state_next = vvs_pkg::ST_COPY_RD;
                end
            end
            vvs_pkg::ST_REPLY:
            begin
                done       = 1'b1;
                state_next = vvs_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = vvs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### sv/vvs_datapath.sv
// Datapath of the voxel volume smoothing block: stores, loop indices and arithmetic.
module vvs_datapath #(
    parameter int MAX_X = vvs_pkg::MAX_X_DEF,
    parameter int MAX_Y = vvs_pkg::MAX_Y_DEF,
    parameter int MAX_Z = vvs_pkg::MAX_Z_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  vvs_pkg::vvs_ctl_t             ctl,
    input  vvs_pkg::vvs_cmd_t             cmd,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [vvs_pkg::CFG_W-1:0]     cfg_data,
    output vvs_pkg::vvs_stat_t            stat,
    output vvs_pkg::vvs_result_t          result
);

    localparam int XW = $clog2(MAX_X);
    localparam int YW = $clog2(MAX_Y);
    localparam int ZW = $clog2(MAX_Z);
    localparam int VOL_AW   = XW + YW + ZW;
    localparam int PLANE_AW = YW + ZW;
    localparam int DIV_IN_W = vvs_pkg::ACC_W - 2;
    localparam int PROD_W   = DIV_IN_W + 16;
    localparam int RECIP_SHIFT_HI = vvs_pkg::RECIP_SHIFT + vvs_pkg::VOX_W - 1;

    localparam logic [2:0] TAP_CENTRE = 3'd0;
    localparam logic [2:0] TAP_ZP     = 3'd1;
    localparam logic [2:0] TAP_ZM     = 3'd2;
    localparam logic [2:0] TAP_YP     = 3'd3;
    localparam logic [2:0] TAP_YM     = 3'd4;
    localparam logic [2:0] TAP_XP     = 3'd5;
    localparam logic [2:0] TAP_XM     = 3'd6;
    localparam logic [2:0] TAP_LAST   = 3'd7;

    logic [vvs_pkg::SIZE_W-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic [vvs_pkg::PASS_W-1:0] passes_reg;
    logic [vvs_pkg::PASS_W-1:0] pass_cnt_reg;
    vvs_pkg::vvs_cmd_t          cmd_reg;
    logic [XW-1:0]              xi_reg;
    logic [YW-1:0]              yi_reg;
    logic [ZW-1:0]              zi_reg;
    logic [vvs_pkg::TAP_W-1:0]  tap_reg;
    logic [vvs_pkg::ACC_W-1:0]  acc_reg;
    logic [PROD_W-1:0]          prod_reg;
    logic                       rd_ok_reg;
    logic                       status_reg;

    logic [vvs_pkg::VOX_W-1:0]  vol_mem [2**VOL_AW];
    logic [vvs_pkg::VOX_W-1:0]  cur_mem [2**PLANE_AW];
    logic [vvs_pkg::VOX_W-1:0]  vol_q_reg;
    logic [vvs_pkg::VOX_W-1:0]  cur_q_reg;

    logic [XW:0] nx;
    logic [YW:0] ny;
    logic [ZW:0] nz;
    logic        no_interior;
    logic        z_end, y_end;
    logic        out_of_range;
    logic [XW-1:0] ax;
    logic [YW-1:0] ay;
    logic [ZW-1:0] az;
    logic [XW-1:0] tx;
    logic [YW-1:0] ty;
    logic [ZW-1:0] tz;
    logic [VOL_AW-1:0] vol_raddr, vol_waddr;
    logic [vvs_pkg::VOX_W-1:0] vol_wdata;
    logic              vol_we;
    logic              step_yz;

    // Sizes above the built maximum act as the maximum.
    assign nx = (32'(size_x_reg) > MAX_X) ? (XW+1)'(MAX_X) : (XW+1)'(size_x_reg);
    assign ny = (32'(size_y_reg) > MAX_Y) ? (YW+1)'(MAX_Y) : (YW+1)'(size_y_reg);
    assign nz = (32'(size_z_reg) > MAX_Z) ? (ZW+1)'(MAX_Z) : (ZW+1)'(size_z_reg);

    assign no_interior = (nx < (XW+1)'(3)) || (ny < (YW+1)'(3)) || (nz < (ZW+1)'(3));
    assign z_end = ({1'b0, zi_reg} == nz - (ZW+1)'(2));
    assign y_end = ({1'b0, yi_reg} == ny - (YW+1)'(2));

    assign stat.run_end    = (pass_cnt_reg == passes_reg) || no_interior;
    assign stat.gather_end = (tap_reg == TAP_LAST);
    assign stat.plane_end  = z_end && y_end;
    assign stat.x_end      = ({1'b0, xi_reg} == nx - (XW+1)'(2));

    assign out_of_range = (32'(cmd_reg.x_index) >= 32'(nx))
                       || (32'(cmd_reg.y_index) >= 32'(ny))
                       || (32'(cmd_reg.z_index) >= 32'(nz));

    assign ax = XW'(cmd_reg.x_index);
    assign ay = YW'(cmd_reg.y_index);
    assign az = ZW'(cmd_reg.z_index);

    // Stencil tap coordinates; the minus-x plane already holds this pass's values.
    always_comb
    begin
        tx = xi_reg;
        ty = yi_reg;
        tz = zi_reg;
        unique case (tap_reg)
            TAP_ZP:  tz = zi_reg + ZW'(1);
            TAP_ZM:  tz = zi_reg - ZW'(1);
            TAP_YP:  ty = yi_reg + YW'(1);
            TAP_YM:  ty = yi_reg - YW'(1);
            TAP_XP:  tx = xi_reg + XW'(1);
            TAP_XM:  tx = xi_reg - XW'(1);
            default: tx = xi_reg;
        endcase
    end

    assign vol_raddr = ctl.gather ? {tx, ty, tz} : {ax, ay, az};
    assign vol_we    = (ctl.access && !out_of_range && cmd_reg.mode == vvs_pkg::MODE_WRITE)
                    || ctl.copy_wr;
    assign vol_waddr = ctl.copy_wr ? {xi_reg, yi_reg, zi_reg} : {ax, ay, az};
    assign vol_wdata = ctl.copy_wr ? cur_q_reg : cmd_reg.voxel_value;
    assign step_yz   = ctl.store || ctl.copy_wr;

    always_ff @(posedge clk)
    begin
        if (vol_we)
        begin
            vol_mem[vol_waddr] <= vol_wdata;
        end
        vol_q_reg <= vol_mem[vol_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.store)
        begin
            cur_mem[{yi_reg, zi_reg}] <= prod_reg[RECIP_SHIFT_HI:vvs_pkg::RECIP_SHIFT];
        end
        cur_q_reg <= cur_mem[{yi_reg, zi_reg}];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= vvs_pkg::SIZE_W'(64);
            size_y_reg <= vvs_pkg::SIZE_W'(64);
            size_z_reg <= vvs_pkg::SIZE_W'(64);
            passes_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                vvs_pkg::REG_SIZE_X: size_x_reg <= cfg_data[vvs_pkg::SIZE_W-1:0];
                vvs_pkg::REG_SIZE_Y: size_y_reg <= cfg_data[vvs_pkg::SIZE_W-1:0];
                vvs_pkg::REG_SIZE_Z: size_z_reg <= cfg_data[vvs_pkg::SIZE_W-1:0];
                vvs_pkg::REG_PASSES: passes_reg <= cfg_data;
                default:             passes_reg <= passes_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_cnt_reg <= '0;
            tap_reg      <= '0;
            rd_ok_reg    <= 1'b0;
            status_reg   <= 1'b0;
            xi_reg       <= '0;
            yi_reg       <= '0;
            zi_reg       <= '0;
        end
        else
        begin
            if (ctl.accept)
            begin
                pass_cnt_reg <= '0;
                tap_reg      <= '0;
                rd_ok_reg    <= 1'b0;
                status_reg   <= 1'b0;
            end
            if (ctl.access)
            begin
                status_reg <= out_of_range && (cmd_reg.mode == vvs_pkg::MODE_WRITE
                                            || cmd_reg.mode == vvs_pkg::MODE_READ);
                rd_ok_reg  <= !out_of_range && cmd_reg.mode == vvs_pkg::MODE_READ;
            end
            if (ctl.pass_init)
            begin
                pass_cnt_reg <= pass_cnt_reg + vvs_pkg::PASS_W'(1);
                xi_reg       <= XW'(1);
                yi_reg       <= YW'(1);
                zi_reg       <= ZW'(1);
            end
            if (ctl.gather)
            begin
                tap_reg <= tap_reg + vvs_pkg::TAP_W'(1);
            end
            if (ctl.divide)
            begin
                tap_reg <= '0;
            end
            if (step_yz)
            begin
                priority if (stat.plane_end)
                begin
                    yi_reg <= YW'(1);
                    zi_reg <= ZW'(1);
                end
                else if (z_end)
                begin
                    zi_reg <= ZW'(1);
                    yi_reg <= yi_reg + YW'(1);
                end
                else
                begin
                    zi_reg <= zi_reg + ZW'(1);
                end
            end
            if (ctl.copy_wr && stat.plane_end)
            begin
                xi_reg <= xi_reg + XW'(1);
            end
        end
    end

    // Payload registers: command capture, accumulator and quotient product.
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            cmd_reg <= cmd;
        end
        if (ctl.accept || ctl.divide)
        begin
            acc_reg <= vvs_pkg::ACC_W'(6);
        end
        else if (ctl.gather && tap_reg != TAP_CENTRE)
        begin
            if (tap_reg == TAP_ZP)
            begin
                acc_reg <= acc_reg + {vvs_pkg::ACC_W'(vol_q_reg) << 2}
                                   + {vvs_pkg::ACC_W'(vol_q_reg) << 1};
            end
            else
            begin
                acc_reg <= acc_reg + vvs_pkg::ACC_W'(vol_q_reg);
            end
        end
        if (ctl.divide)
        begin
            // floor(acc / 12) = floor(floor(acc / 4) / 3)
            prod_reg <= PROD_W'(acc_reg[vvs_pkg::ACC_W-1:2]) * PROD_W'(vvs_pkg::RECIP3);
        end
    end

    assign result.read_value = rd_ok_reg ? vol_q_reg : '0;
    assign result.status     = status_reg;

endmodule

### sv/voxel_volume_smoothing.sv
// Top level of the voxel volume smoothing block.
//
// Commands arrive on cmd and are taken when start is high while busy is low.
// Mode write stores one voxel byte, mode read returns one, and mode run performs the
// configured number of seven-point smoothing passes over the interior of the volume.
// Every command gives exactly one result on result, shown for a single cycle with done high.
// Write, read and unused modes pass from acceptance through an access state to the reply
// state, where the result is shown; the block is then idle again.
// A run shows its result in the reply state once all passes are done. Each pass begins
// with a set-up state; each interior voxel then has its seven stencil values gathered
// through the single read port of the volume store, followed by a divide step and a store
// into the plane buffer, and each finished plane is copied back into the volume voxel by
// voxel through a read and a write step.
// Configuration registers are written through cfg_valid/cfg_ready with cfg_index and
// cfg_data; each write transaction completes while the block is idle.
// Reset returns the controller to idle, sizes to 64 and the pass count to zero;
// the voxel store itself is not cleared and holds nothing meaningful until written.
// The receiver of results cannot stall, so no result is ever held back.
module voxel_volume_smoothing #(
    parameter int MAX_X = vvs_pkg::MAX_X_DEF,
    parameter int MAX_Y = vvs_pkg::MAX_Y_DEF,
    parameter int MAX_Z = vvs_pkg::MAX_Z_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  vvs_pkg::vvs_cmd_t         cmd,
    output logic                      done,
    output vvs_pkg::vvs_result_t      result,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [vvs_pkg::CFG_W-1:0] cfg_data
);

    vvs_pkg::vvs_ctl_t  ctl;
    vvs_pkg::vvs_stat_t stat;

    // Register writes are taken whenever the block is idle.
    assign cfg_ready = !busy;

    vvs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (cmd.mode),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    vvs_datapath #(
        .MAX_X (MAX_X),
        .MAX_Y (MAX_Y),
        .MAX_Z (MAX_Z)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .cmd       (cmd),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stat      (stat),
        .result    (result)
    );

endmodule

### sv/vvs_checker.sv
// Port-level checker of the voxel volume smoothing block and its bind.
`include "voxel_volume_smoothing_assert.svh"

module vvs_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 done,
    input vvs_pkg::vvs_result_t result
);

    `VVS_ASSERT(a_accept_busy, (start && !busy) |=> busy, "busy not raised after acceptance")
    `VVS_ASSERT(a_done_frees, done |=> !busy, "block not idle after a result")
    `VVS_NEVER(a_done_idle, done && !busy, "result shown while idle")
    `VVS_NEVER(a_err_value, done && result.status && (result.read_value != '0), "error carries data")

endmodule

bind voxel_volume_smoothing vvs_checker u_vvs_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
